@@ hdl/ppli_pkg.sv @@
// Shared constants, widths and the reciprocal table for the pixel pair interpolator.
// No dependencies.
package ppli_pkg;

  localparam int COORD_BITS_DFLT = 12;
  localparam int COLOR_W         = 8;
  localparam int ZOOM_W          = 7;
  localparam int CNT_W           = 6;
  localparam int RECIP_W         = 16;
  localparam int RECIP_SHIFT     = 16;
  localparam int STEP_W          = 7;
  localparam int DIV_PROD_W      = COLOR_W + RECIP_W;
  localparam int MUL_PROD_W      = CNT_W + STEP_W;
  localparam int RECIP_DEPTH     = 65;

  localparam logic [ZOOM_W-1:0] ZOOM_MAX   = 7'd64;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET = 7'd4;
  localparam logic [ZOOM_W-1:0] ZOOM_MIN   = 7'd2;

  // ceil(2^16 / k); k of 0 and 1 never produce results
  localparam logic [RECIP_W-1:0] RECIP_TBL [RECIP_DEPTH] = '{
    16'd0,     16'd0,     16'd32768, 16'd21846, 16'd16384, 16'd13108, 16'd10923, 16'd9363,
    16'd8192,  16'd7282,  16'd6554,  16'd5958,  16'd5462,  16'd5042,  16'd4682,  16'd4370,
    16'd4096,  16'd3856,  16'd3641,  16'd3450,  16'd3277,  16'd3121,  16'd2979,  16'd2850,
    16'd2731,  16'd2622,  16'd2521,  16'd2428,  16'd2341,  16'd2260,  16'd2185,  16'd2115,
    16'd2048,  16'd1986,  16'd1928,  16'd1873,  16'd1821,  16'd1772,  16'd1725,  16'd1681,
    16'd1639,  16'd1599,  16'd1561,  16'd1525,  16'd1490,  16'd1457,  16'd1425,  16'd1395,
    16'd1366,  16'd1338,  16'd1311,  16'd1286,  16'd1261,  16'd1237,  16'd1214,  16'd1192,
    16'd1171,  16'd1150,  16'd1130,  16'd1111,  16'd1093,  16'd1075,  16'd1058,  16'd1041,
    16'd1024
  };

  function automatic logic [ZOOM_W-1:0] zoom_clamp(input logic [ZOOM_W-1:0] k);
    zoom_clamp = (k > ZOOM_MAX) ? ZOOM_MAX : k;
  endfunction

  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [ZOOM_W-1:0] k);
    recip_lookup = RECIP_TBL[k];
  endfunction

endpackage

@@ hdl/ppli_pair_if.sv @@
// Request channel: two endpoint pixels, base position and fill direction.
// Depends on ppli_pkg.
interface ppli_pair_if #(parameter int COORD_BITS = ppli_pkg::COORD_BITS_DFLT);
  import ppli_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COLOR_W-1:0]    first_blue;
  logic [COLOR_W-1:0]    first_green;
  logic [COLOR_W-1:0]    first_red;
  logic [COLOR_W-1:0]    second_blue;
  logic [COLOR_W-1:0]    second_green;
  logic [COLOR_W-1:0]    second_red;
  logic [COORD_BITS-1:0] base_row;
  logic [COORD_BITS-1:0] base_col;
  logic                  direction;

  modport source (
    output valid, first_blue, first_green, first_red,
           second_blue, second_green, second_red, base_row, base_col, direction,
    input  ready
  );

  modport sink (
    input  valid, first_blue, first_green, first_red,
           second_blue, second_green, second_red, base_row, base_col, direction,
    output ready
  );

endinterface

@@ hdl/ppli_px_if.sv @@
// Result channel: one interpolated pixel with its position and run-end mark.
// Depends on ppli_pkg.
interface ppli_px_if #(parameter int COORD_BITS = ppli_pkg::COORD_BITS_DFLT);
  import ppli_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_row;
  logic [COORD_BITS-1:0] out_col;
  logic [COLOR_W-1:0]    out_blue;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_red;
  logic                  last_of_run;

  modport source (
    output valid, out_row, out_col, out_blue, out_green, out_red, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, out_row, out_col, out_blue, out_green, out_red, last_of_run,
    output ready
  );

endinterface

@@ hdl/ppli_chan.sv @@
// One color channel of the interpolator: four pipeline stages
// (order/diff, divide by reciprocal, scale by index, add base). Depends on ppli_pkg.
module ppli_chan (
  input  logic                            clk,
  input  logic                            en,
  input  logic [ppli_pkg::COLOR_W-1:0]    a,
  input  logic [ppli_pkg::COLOR_W-1:0]    b,
  input  logic [ppli_pkg::CNT_W-1:0]      idx,
  input  logic [ppli_pkg::ZOOM_W-1:0]     k,
  input  logic [ppli_pkg::RECIP_W-1:0]    recip,
  output logic [ppli_pkg::COLOR_W-1:0]    value
);
  import ppli_pkg::*;

  logic [COLOR_W-1:0]    diff1_r, lo1_r, lo2_r, lo3_r, val4_r;
  logic [CNT_W-1:0]      m1_r, m2_r;
  logic [STEP_W-1:0]     step2_r;
  logic [COLOR_W-1:0]    mstep3_r;
  logic                  gt;
  logic [ZOOM_W-1:0]     rev_idx;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [MUL_PROD_W-1:0] mul_prod;

  always_comb begin
    gt       = a > b;
    rev_idx  = k - {1'b0, idx};
    div_prod = diff1_r * recip;
    mul_prod = m2_r * step2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff1_r  <= gt ? (a - b) : (b - a);
      lo1_r    <= gt ? b : a;
      m1_r     <= gt ? rev_idx[CNT_W-1:0] : idx;
      step2_r  <= div_prod[RECIP_SHIFT +: STEP_W];
      lo2_r    <= lo1_r;
      m2_r     <= m1_r;
      // index * step never exceeds the endpoint difference
      mstep3_r <= mul_prod[COLOR_W-1:0];
      lo3_r    <= lo2_r;
      val4_r   <= lo3_r + mstep3_r;
    end
  end

  assign value = val4_r;

endmodule

@@ hdl/pixel_pair_linear_interpolator.sv @@
// A request is registered by the result sequencer, then flows through the channel pipeline.
// Throughput: one result per cycle while the output is not stalled; a request yields k-1
// results (k = clamped zoom factor), counted by the result sequencer; with k below 2, none.
// Reset: zoom factor 4, sequencer idle, pipeline empty.
// Top level; depends on ppli_pkg, ppli_pair_if, ppli_px_if and ppli_chan.
module pixel_pair_linear_interpolator #(
  parameter int COORD_BITS = ppli_pkg::COORD_BITS_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ppli_pair_if.sink                     in_pair,
  ppli_px_if.source                     out_px,
  input  logic                          cfg_wr_en,
  input  logic [ppli_pkg::ZOOM_W-1:0]   cfg_wr_data
);
  import ppli_pkg::*;

  localparam int NSTG = 4;

  logic [ZOOM_W-1:0]     k_r;
  logic [RECIP_W-1:0]    recip_r;
  logic [ZOOM_W-1:0]     k_nxt;

  logic                  busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [COLOR_W-1:0]    fb_r, fg_r, fr_r, sb_r, sg_r, sr_r;
  logic [COORD_BITS-1:0] row_r, col_r;
  logic                  dir_r;

  logic [NSTG-1:0]       vld_r;
  logic [COORD_BITS-1:0] row_s_r [NSTG];
  logic [COORD_BITS-1:0] col_s_r [NSTG];
  logic [NSTG-1:0]       last_s_r;

  logic                  adv, last_beat, acc;
  logic [COORD_BITS-1:0] idx_ext;

  assign k_nxt     = zoom_clamp(cfg_wr_data);
  assign adv       = !vld_r[NSTG-1] || out_px.ready;
  assign last_beat = {1'b0, cnt_r} == (k_r - 1'b1);
  assign in_pair.ready = adv && (!busy_r || last_beat);
  assign acc       = in_pair.valid && in_pair.ready;
  assign idx_ext   = {{(COORD_BITS-CNT_W){1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= ZOOM_RESET;
      recip_r <= recip_lookup(ZOOM_RESET);
    end else if (cfg_wr_en) begin
      k_r     <= k_nxt;
      recip_r <= recip_lookup(k_nxt);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (acc) begin
      busy_nxt = k_r >= ZOOM_MIN;
      cnt_nxt  = CNT_W'(1);
    end else if (busy_r && adv) begin
      if (last_beat) begin
        busy_nxt = 1'b0;
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fb_r  <= in_pair.first_blue;
      fg_r  <= in_pair.first_green;
      fr_r  <= in_pair.first_red;
      sb_r  <= in_pair.second_blue;
      sg_r  <= in_pair.second_green;
      sr_r  <= in_pair.second_red;
      row_r <= in_pair.base_row;
      col_r <= in_pair.base_col;
      dir_r <= in_pair.direction;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], busy_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_s_r[0]  <= dir_r ? (row_r + idx_ext) : row_r;
      col_s_r[0]  <= dir_r ? col_r : (col_r + idx_ext);
      last_s_r[0] <= last_beat;
      for (int s = 1; s < NSTG; s++) begin
        row_s_r[s]  <= row_s_r[s-1];
        col_s_r[s]  <= col_s_r[s-1];
        last_s_r[s] <= last_s_r[s-1];
      end
    end
  end

  ppli_chan u_blue (
    .clk(clk), .en(adv), .a(fb_r), .b(sb_r), .idx(cnt_r), .k(k_r), .recip(recip_r),
    .value(out_px.out_blue)
  );

  ppli_chan u_green (
    .clk(clk), .en(adv), .a(fg_r), .b(sg_r), .idx(cnt_r), .k(k_r), .recip(recip_r),
    .value(out_px.out_green)
  );

  ppli_chan u_red (
    .clk(clk), .en(adv), .a(fr_r), .b(sr_r), .idx(cnt_r), .k(k_r), .recip(recip_r),
    .value(out_px.out_red)
  );

  assign out_px.valid       = vld_r[NSTG-1];
  assign out_px.out_row     = row_s_r[NSTG-1];
  assign out_px.out_col     = col_s_r[NSTG-1];
  assign out_px.last_of_run = last_s_r[NSTG-1];

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pixel_pair_linear_interpolator: directed and random requests
// under varying zoom factors, predicted in place and compared pixel by pixel with the result
// stream. Depends on ppli_pkg, ppli_pair_if, ppli_px_if and the interpolator RTL.
module tb_top;
  import ppli_pkg::*;

  localparam int CW = COORD_BITS_DFLT;

  typedef struct {
    logic [COLOR_W-1:0] fb, fg, fr, sb, sg, sr;
    logic [CW-1:0]      row, col;
    logic               down;
  } pair_req_t;

  typedef struct {
    logic [CW-1:0]      row, col;
    logic [COLOR_W-1:0] b, g, r;
    logic               last;
  } interp_px_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [ZOOM_W-1:0] cfg_wr_data;

  ppli_pair_if #(.COORD_BITS(CW)) in_pair ();
  ppli_px_if   #(.COORD_BITS(CW)) out_px ();

  pixel_pair_linear_interpolator #(.COORD_BITS(CW)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pair     (in_pair),
    .out_px      (out_px),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  pair_req_t   pending_pairs[$];
  interp_px_t  expected_px[$];
  pair_req_t   on_bus;
  int unsigned zoom_k;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          errors;
  int          reqs_sent;
  int          px_checked;
  int          zoom_writes;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [COLOR_W-1:0] lerp_channel(logic [COLOR_W-1:0] a,
                                                      logic [COLOR_W-1:0] b,
                                                      int unsigned k, int unsigned i);
    int unsigned step;
    if (a > b) begin
      step = (int'(a) - int'(b)) / k;
      return COLOR_W'(int'(b) + (k - i) * step);
    end
    step = (int'(b) - int'(a)) / k;
    return COLOR_W'(int'(a) + i * step);
  endfunction

  function automatic void predict_pixels(pair_req_t p);
    int unsigned k;
    interp_px_t  px;
    k = (zoom_k > 64) ? 64 : zoom_k;
    if (k < 2)
      return;
    for (int unsigned i = 1; i < k; i++) begin
      px.row  = p.down ? p.row + CW'(i) : p.row;
      px.col  = p.down ? p.col : p.col + CW'(i);
      px.b    = lerp_channel(p.fb, p.sb, k, i);
      px.g    = lerp_channel(p.fg, p.sg, k, i);
      px.r    = lerp_channel(p.fr, p.sr, k, i);
      px.last = (i == k - 1);
      expected_px.push_back(px);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_pair.valid        <= 1'b0;
      in_pair.first_blue   <= '0;
      in_pair.first_green  <= '0;
      in_pair.first_red    <= '0;
      in_pair.second_blue  <= '0;
      in_pair.second_green <= '0;
      in_pair.second_red   <= '0;
      in_pair.base_row     <= '0;
      in_pair.base_col     <= '0;
      in_pair.direction    <= 1'b0;
    end else if (!in_pair.valid || in_pair.ready) begin
      if (in_pair.valid) begin
        predict_pixels(on_bus);
        reqs_sent++;
      end
      if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        on_bus = pending_pairs.pop_front();
        in_pair.valid        <= 1'b1;
        in_pair.first_blue   <= on_bus.fb;
        in_pair.first_green  <= on_bus.fg;
        in_pair.first_red    <= on_bus.fr;
        in_pair.second_blue  <= on_bus.sb;
        in_pair.second_green <= on_bus.sg;
        in_pair.second_red   <= on_bus.sr;
        in_pair.base_row     <= on_bus.row;
        in_pair.base_col     <= on_bus.col;
        in_pair.direction    <= on_bus.down;
      end else begin
        in_pair.valid <= 1'b0;
      end
    end
  end

  // pixel monitor
  always @(posedge clk) begin : px_monitor
    interp_px_t want;
    if (!rst_n) begin
      out_px.ready <= 1'b0;
    end else begin
      if (out_px.valid && out_px.ready) begin
        if (expected_px.size() == 0) begin
          $error("unexpected pixel at row %0d col %0d", out_px.out_row, out_px.out_col);
          errors++;
        end else begin
          want = expected_px.pop_front();
          check_field("out_row", want.row, out_px.out_row);
          check_field("out_col", want.col, out_px.out_col);
          check_field("out_blue", want.b, out_px.out_blue);
          check_field("out_green", want.g, out_px.out_green);
          check_field("out_red", want.r, out_px.out_red);
          check_field("last_of_run", want.last, out_px.last_of_run);
          px_checked++;
        end
      end
      out_px.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_pair(logic [7:0] fb, logic [7:0] fg, logic [7:0] fr,
                          logic [7:0] sb, logic [7:0] sg, logic [7:0] sr,
                          logic [CW-1:0] row, logic [CW-1:0] col, logic down);
    pair_req_t p;
    p = '{fb, fg, fr, sb, sg, sr, row, col, down};
    pending_pairs.push_back(p);
  endtask

  function automatic logic [COLOR_W-1:0] rand_color(int unsigned style, logic [7:0] other);
    case (style)
      0: return COLOR_W'($urandom_range(255));
      1: return other;
      2: return $urandom_range(1) ? 8'd255 : 8'd0;
      default: return 8'(int'(other) + $urandom_range(6) - 3);
    endcase
  endfunction

  function automatic pair_req_t rand_pair();
    pair_req_t   p;
    int unsigned style;
    style = $urandom_range(5);
    if (style > 3)
      style = 0;
    p.fb = COLOR_W'($urandom_range(255));
    p.fg = COLOR_W'($urandom_range(255));
    p.fr = COLOR_W'($urandom_range(255));
    p.sb = rand_color(style, p.fb);
    p.sg = rand_color(style, p.fg);
    p.sr = rand_color(style, p.fr);
    p.row  = ($urandom_range(7) == 0) ? CW'(4095 - $urandom_range(70)) : CW'($urandom);
    p.col  = ($urandom_range(7) == 0) ? CW'(4095 - $urandom_range(70)) : CW'($urandom);
    p.down = 1'($urandom_range(1));
    return p;
  endfunction

  // block is idle once nothing is queued, on the bus or outstanding
  task automatic drain();
    do
      @(negedge clk);
    while (pending_pairs.size() != 0 || in_pair.valid || expected_px.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_zoom(int unsigned k);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ZOOM_W'(k);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    zoom_k = k;
    zoom_writes++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned k;
    rst_n                <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    zoom_k        = ZOOM_RESET;
    send_idle_pct = 28;
    recv_idle_pct = 51;
    errors        = 0;
    reqs_sent     = 0;
    px_checked    = 0;
    zoom_writes   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed requests at the reset zoom factor, then at zoom factors 64, 2, 1, 0, 100 and 127
    add_pair(0, 0, 0, 255, 255, 255, 0, 0, 0);
    add_pair(255, 255, 255, 0, 0, 0, 0, 0, 1);
    add_pair(128, 128, 128, 128, 128, 128, 4095, 4095, 0);
    add_pair(7, 200, 99, 7, 200, 99, 4095, 4095, 1);
    add_pair(10, 250, 77, 250, 10, 77, 4094, 2, 1);
    add_pair(5, 8, 0, 8, 5, 3, 100, 4093, 0);
    drain();
    write_zoom(64);
    add_pair(255, 0, 200, 0, 255, 13, 12, 4000, 0);
    add_pair(0, 255, 1, 255, 0, 254, 4090, 33, 1);
    drain();
    write_zoom(2);
    add_pair(0, 255, 3, 255, 0, 4, 4095, 4095, 0);
    add_pair(255, 1, 90, 0, 2, 91, 4095, 4095, 1);
    drain();
    write_zoom(1);
    add_pair(0, 0, 0, 255, 255, 255, 1, 1, 0);
    add_pair(255, 255, 255, 0, 0, 0, 1, 1, 1);
    drain();
    write_zoom(0);
    add_pair(1, 2, 3, 4, 5, 6, 7, 8, 1);
    drain();
    write_zoom(100);
    add_pair(255, 0, 128, 0, 255, 128, 300, 4070, 0);
    drain();
    write_zoom(127);
    add_pair(0, 255, 64, 255, 0, 192, 4080, 5, 1);
    drain();

    // random requests, three idling regimes, zoom changed per segment
    for (int seg = 0; seg < 12; seg++) begin
      send_idle_pct = (seg < 4) ? 28 : (seg < 8) ? 51 : 0;
      recv_idle_pct = (seg < 4) ? 51 : (seg < 8) ? 28 : 0;
      k = ($urandom_range(9) == 0) ? $urandom_range(127, 9) : $urandom_range(8);
      write_zoom(k);
      repeat (32) pending_pairs.push_back(rand_pair());
      drain();
    end

    repeat (20) @(negedge clk);
    if (expected_px.size() != 0) begin
      $error("%0d pixels never arrived", expected_px.size());
      errors++;
    end
    $display("Ran %0d requests under %0d zoom factor writes, %0d interpolated pixels checked.",
             reqs_sent, zoom_writes, px_checked);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
